/* rtl/kti_pkg.sv */
package kti_pkg;

	localparam logic [16:0] ONE_Q16 = 17'h10000;
	localparam int MN_W = 30;
	localparam int SQ_W = 62;
	localparam int LEN_W = 31;
	localparam int LANE_W = 16;

	typedef struct packed {
		logic [15:0] tag;
		logic [47:0] first;
		logic [47:0] second;
		logic [47:0] third;
	} side_t;

	typedef struct packed {
		side_t side;
		logic [2:0] neg;
		logic zero;
		logic [2:0][MN_W-1:0] mag;
	} carry_t;

endpackage

/* rtl/keyframe_triangle_interpolator_core.sv */
// Path from input request to result: blend, cross-product, scale, square-root, divider, output register.
// Throughput: one triangle per cycle; every stage advances together on a free output.
// The square root takes 31 stages, one root bit each; the divider, after a setup stage, one quotient bit a stage.
// Reset: arst_n clears all stage valid bits and sets blend_fraction to zero.
module keyframe_triangle_interpolator_core #(
	parameter int COORD_WIDTH = 16,
	parameter int NORMAL_FRAC_BITS = 14
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [16:0] cfg_wr_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic [15:0] triangle_tag,
	input  logic [47:0] cur_vertex_a,
	input  logic [47:0] cur_vertex_b,
	input  logic [47:0] cur_vertex_c,
	input  logic [47:0] next_vertex_a,
	input  logic [47:0] next_vertex_b,
	input  logic [47:0] next_vertex_c,
	output logic out_valid,
	input  logic out_stall,
	output logic [15:0] tag_out,
	output logic [47:0] emit_first,
	output logic [47:0] emit_second,
	output logic [47:0] emit_third,
	output logic [47:0] unit_normal,
	output logic normal_valid
);

	localparam int CW = COORD_WIDTH;
	localparam int QW = NORMAL_FRAC_BITS + 1;

	logic [16:0] blend_fraction_q;
	logic [16:0] f_sat;
	logic adv;
	logic [47:0] cur [3];
	logic [47:0] nxt [3];

	logic v1;
	logic [3*CW-1:0] vert1 [3];
	kti_pkg::side_t side1;
	logic v3;
	logic [2*CW+1:0] mag3 [3];
	logic [2:0] neg3;
	logic zero3;
	kti_pkg::side_t side3;
	logic v7;
	logic [kti_pkg::SQ_W-1:0] sum7;
	kti_pkg::carry_t cr7;
	logic vsq;
	logic [kti_pkg::LEN_W-1:0] len_sq;
	kti_pkg::carry_t cr_sq;
	logic vdv;
	logic [QW-1:0] quot [3];
	kti_pkg::carry_t cr_dv;

	logic [QW+14:0] qe [3];
	logic [14:0] qs [3];
	logic [15:0] lane [3];

	logic out_valid_q;
	kti_pkg::side_t side_q;
	logic [47:0] normal_q;
	logic nvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_fraction_q <= '0;
		end else if (cfg_wr_en) begin
			blend_fraction_q <= cfg_wr_data;
		end
	end

	assign f_sat = (blend_fraction_q > kti_pkg::ONE_Q16) ? kti_pkg::ONE_Q16 : blend_fraction_q;
	assign adv = !(out_valid_q && out_stall);
	assign in_stall = !adv;

	assign cur[0] = cur_vertex_a;
	assign cur[1] = cur_vertex_b;
	assign cur[2] = cur_vertex_c;
	assign nxt[0] = next_vertex_a;
	assign nxt[1] = next_vertex_b;
	assign nxt[2] = next_vertex_c;

	kti_blend #(.COORD_WIDTH(CW)) u_blend (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(in_valid), .f(f_sat),
		.tag(triangle_tag), .cur(cur), .nxt(nxt),
		.valid_s1(v1), .vert_s1(vert1), .side_s1(side1)
	);

	kti_cross #(.COORD_WIDTH(CW)) u_cross (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v1), .vert(vert1),
		.side_in(side1), .valid_s3(v3), .mag_s3(mag3), .neg_s3(neg3),
		.zero_s3(zero3), .side_s3(side3)
	);

	kti_scale #(.COORD_WIDTH(CW)) u_scale (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v3), .mag(mag3),
		.neg(neg3), .zero(zero3), .side_in(side3),
		.valid_s7(v7), .sum_s7(sum7), .carry_s7(cr7)
	);

	kti_isqrt u_isqrt (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v7), .x(sum7),
		.carry_in(cr7), .valid_out(vsq), .len(len_sq), .carry_out(cr_sq)
	);

	kti_divide #(.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)) u_divide (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(vsq), .len(len_sq),
		.carry_in(cr_sq), .valid_out(vdv), .quot(quot), .carry_out(cr_dv)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qe[i] = {15'b0, quot[i]};
			qs[i] = (qe[i] > (QW+15)'(32767)) ? 15'h7fff : qe[i][14:0];
			if (cr_dv.zero) begin
				lane[i] = '0;
			end else if (cr_dv.neg[i]) begin
				lane[i] = 16'd0 - {1'b0, qs[i]};
			end else begin
				lane[i] = {1'b0, qs[i]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vdv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_q <= cr_dv.side;
			normal_q <= {lane[2], lane[1], lane[0]};
			nvalid_q <= !cr_dv.zero;
		end
	end

	assign out_valid = out_valid_q;
	assign tag_out = side_q.tag;
	assign emit_first = side_q.first;
	assign emit_second = side_q.second;
	assign emit_third = side_q.third;
	assign unit_normal = normal_q;
	assign normal_valid = nvalid_q;

`ifndef NO_ASSERTIONS
	a_zero_normal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !normal_valid |-> unit_normal == '0)
		else $error("invalid normal carries nonzero lanes");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		vsq && !cr_sq.zero |-> len_sq[kti_pkg::LEN_W-1:kti_pkg::LEN_W-2] != 2'b00)
		else $error("root below normalized range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vdv) && $stable(quot[0]))
		else $error("divider moved while output held");
`endif

endmodule

/* rtl/kti_blend.sv */
module kti_blend #(
	parameter int COORD_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [16:0] f,
	input  logic [15:0] tag,
	input  logic [47:0] cur [3],
	input  logic [47:0] nxt [3],
	output logic valid_s1,
	output logic [3*COORD_WIDTH-1:0] vert_s1 [3],
	output kti_pkg::side_t side_s1
);

	localparam int CW = COORD_WIDTH;
	localparam int PW = 3 * CW;
	localparam int PRW = CW + 19;

	logic [PW+47:0] ce [3];
	logic [PW+47:0] ne [3];
	logic signed [CW-1:0] a_l [3][3];
	logic signed [CW-1:0] b_l [3][3];
	logic signed [CW:0] d_l [3][3];
	logic signed [PRW-1:0] prod [3][3];
	logic signed [PRW-1:0] rnd [3][3];
	logic signed [PRW-1:0] sh [3][3];
	logic [CW-1:0] bl [3][3];
	logic [PW-1:0] pv [3];
	logic [PW+47:0] pk [3];

	always_comb begin
		for (int v = 0; v < 3; v++) begin
			ce[v] = {{PW{1'b0}}, cur[v]};
			ne[v] = {{PW{1'b0}}, nxt[v]};
			for (int i = 0; i < 3; i++) begin
				a_l[v][i] = ce[v][i*CW +: CW];
				b_l[v][i] = ne[v][i*CW +: CW];
				d_l[v][i] = $signed({b_l[v][i][CW-1], b_l[v][i]})
					- $signed({a_l[v][i][CW-1], a_l[v][i]});
				prod[v][i] = $signed({1'b0, f}) * d_l[v][i];
				rnd[v][i] = prod[v][i] + PRW'(32768);
				sh[v][i] = rnd[v][i] >>> 16;
				bl[v][i] = a_l[v][i] + sh[v][i][CW-1:0];
			end
			pv[v] = {bl[v][2], bl[v][1], bl[v][0]};
			pk[v] = {48'b0, pv[v]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int v = 0; v < 3; v++) begin
				vert_s1[v] <= pv[v];
			end
			side_s1.tag <= tag;
			side_s1.first <= pk[0][47:0];
			side_s1.second <= pk[2][47:0];
			side_s1.third <= pk[1][47:0];
		end
	end

endmodule

/* rtl/kti_cross.sv */
module kti_cross #(
	parameter int COORD_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [3*COORD_WIDTH-1:0] vert [3],
	input  kti_pkg::side_t side_in,
	output logic valid_s3,
	output logic [2*COORD_WIDTH+1:0] mag_s3 [3],
	output logic [2:0] neg_s3,
	output logic zero_s3,
	output kti_pkg::side_t side_s3
);

	localparam int CW = COORD_WIDTH;
	localparam int PW2 = 2 * CW + 2;
	localparam int NW = 2 * CW + 3;
	localparam int MW = 2 * CW + 2;

	logic signed [CW-1:0] ln [3][3];
	logic signed [CW:0] u [3];
	logic signed [CW:0] w [3];
	logic signed [PW2-1:0] prd [6];
	logic signed [PW2-1:0] prd_s2 [6];
	logic valid_s2;
	kti_pkg::side_t side_s2;
	logic signed [NW-1:0] n [3];
	logic [NW-1:0] an [3];

	always_comb begin
		for (int v = 0; v < 3; v++) begin
			for (int i = 0; i < 3; i++) begin
				ln[v][i] = vert[v][i*CW +: CW];
			end
		end
		for (int i = 0; i < 3; i++) begin
			u[i] = $signed({ln[0][i][CW-1], ln[0][i]}) - $signed({ln[1][i][CW-1], ln[1][i]});
			w[i] = $signed({ln[2][i][CW-1], ln[2][i]}) - $signed({ln[1][i][CW-1], ln[1][i]});
		end
		prd[0] = PW2'(u[1]) * PW2'(w[2]);
		prd[1] = PW2'(u[2]) * PW2'(w[1]);
		prd[2] = PW2'(u[2]) * PW2'(w[0]);
		prd[3] = PW2'(u[0]) * PW2'(w[2]);
		prd[4] = PW2'(u[0]) * PW2'(w[1]);
		prd[5] = PW2'(u[1]) * PW2'(w[0]);
		for (int i = 0; i < 3; i++) begin
			n[i] = NW'(prd_s2[2*i]) - NW'(prd_s2[2*i+1]);
			an[i] = n[i][NW-1] ? NW'(-n[i]) : NW'(n[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s2 <= in_valid;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prd_s2 <= prd;
			side_s2 <= side_in;
			for (int i = 0; i < 3; i++) begin
				mag_s3[i] <= an[i][MW-1:0];
				neg_s3[i] <= n[i][NW-1];
			end
			zero_s3 <= (n[0] == '0) && (n[1] == '0) && (n[2] == '0);
			side_s3 <= side_s2;
		end
	end

endmodule

/* rtl/kti_scale.sv */
module kti_scale #(
	parameter int COORD_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [2*COORD_WIDTH+1:0] mag [3],
	input  logic [2:0] neg,
	input  logic zero,
	input  kti_pkg::side_t side_in,
	output logic valid_s7,
	output logic [kti_pkg::SQ_W-1:0] sum_s7,
	output kti_pkg::carry_t carry_s7
);

	localparam int MW = 2 * COORD_WIDTH + 2;
	localparam int PLW = $clog2(MW);
	localparam int EW = MW + kti_pkg::MN_W;

	logic [MW-1:0] orv;
	logic [PLW-1:0] lead;
	logic [MW-1:0] m_s4 [3];
	logic [PLW-1:0] lead_s4;
	kti_pkg::carry_t cr_s4, cr_s5, cr_s6;
	logic valid_s4, valid_s5, valid_s6;
	logic [EW-1:0] ex [3];
	logic [kti_pkg::MN_W-1:0] mn [3];
	logic [2*kti_pkg::MN_W-1:0] sq_s6 [3];

	always_comb begin
		orv = mag[0] | mag[1] | mag[2];
		lead = '0;
		for (int i = 0; i < MW; i++) begin
			if (orv[i]) begin
				lead = PLW'(i);
			end
		end
		for (int i = 0; i < 3; i++) begin
			ex[i] = {m_s4[i], {kti_pkg::MN_W{1'b0}}} >> ((PLW+1)'(lead_s4) + (PLW+1)'(1));
			mn[i] = ex[i][kti_pkg::MN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s4 <= in_valid;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s4 <= mag;
			lead_s4 <= lead;
			cr_s4.side <= side_in;
			cr_s4.neg <= neg;
			cr_s4.zero <= zero;
			cr_s4.mag <= '0;
			cr_s5.side <= cr_s4.side;
			cr_s5.neg <= cr_s4.neg;
			cr_s5.zero <= cr_s4.zero;
			for (int i = 0; i < 3; i++) begin
				cr_s5.mag[i] <= mn[i];
				sq_s6[i] <= cr_s5.mag[i] * cr_s5.mag[i];
			end
			cr_s6 <= cr_s5;
			sum_s7 <= kti_pkg::SQ_W'(sq_s6[0]) + kti_pkg::SQ_W'(sq_s6[1])
				+ kti_pkg::SQ_W'(sq_s6[2]);
			carry_s7 <= cr_s6;
		end
	end

endmodule

/* rtl/kti_isqrt.sv */
module kti_isqrt (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [kti_pkg::SQ_W-1:0] x,
	input  kti_pkg::carry_t carry_in,
	output logic valid_out,
	output logic [kti_pkg::LEN_W-1:0] len,
	output kti_pkg::carry_t carry_out
);

	localparam int N = 31;
	localparam int XW = kti_pkg::SQ_W;

	logic [XW-1:0] rem_s [N];
	logic [XW-1:0] root_s [N];
	kti_pkg::carry_t cr_s [N];
	logic v_s [N];

	logic [XW-1:0] rem_i [N];
	logic [XW-1:0] root_i [N];
	kti_pkg::carry_t cr_i [N];
	logic v_i [N];

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam logic [XW-1:0] BIT = XW'(1) << (60 - 2 * k);
		logic [XW:0] t;
		logic ge;
		logic [XW-1:0] nrem, nroot;

		if (k == 0) begin : g_first
			assign rem_i[k] = x;
			assign root_i[k] = '0;
			assign cr_i[k] = carry_in;
			assign v_i[k] = in_valid;
		end else begin : g_next
			assign rem_i[k] = rem_s[k-1];
			assign root_i[k] = root_s[k-1];
			assign cr_i[k] = cr_s[k-1];
			assign v_i[k] = v_s[k-1];
		end

		always_comb begin
			t = {1'b0, root_i[k]} + {1'b0, BIT};
			ge = {1'b0, rem_i[k]} >= t;
			nrem = ge ? rem_i[k] - t[XW-1:0] : rem_i[k];
			nroot = ge ? (root_i[k] >> 1) + BIT : root_i[k] >> 1;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_i[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= nrem;
				root_s[k] <= nroot;
				cr_s[k] <= cr_i[k];
			end
		end
	end

	assign valid_out = v_s[N-1];
	assign len = root_s[N-1][kti_pkg::LEN_W-1:0];
	assign carry_out = cr_s[N-1];

endmodule

/* rtl/kti_divide.sv */
module kti_divide #(
	parameter int NORMAL_FRAC_BITS = 14
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [kti_pkg::LEN_W-1:0] len,
	input  kti_pkg::carry_t carry_in,
	output logic valid_out,
	output logic [NORMAL_FRAC_BITS:0] quot [3],
	output kti_pkg::carry_t carry_out
);

	localparam int NF = NORMAL_FRAC_BITS;
	localparam int QW = NF + 1;
	localparam int NS = NF + 2;
	localparam int DW = kti_pkg::LEN_W + NF;

	logic [DW-1:0] rem_s [NS][3];
	logic [QW-1:0] q_s [NS][3];
	logic [kti_pkg::LEN_W-1:0] len_s [NS];
	kti_pkg::carry_t cr_s [NS];
	logic v_s [NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				rem_s[0][i] <= (DW'(carry_in.mag[i]) << NF) + DW'(len >> 1);
				q_s[0][i] <= '0;
			end
			len_s[0] <= len;
			cr_s[0] <= carry_in;
		end
	end

	for (genvar j = 1; j < NS; j++) begin : g_bit
		localparam int K = NS - 1 - j;
		logic [DW-1:0] dv;
		logic ge [3];
		logic [DW-1:0] nrem [3];

		always_comb begin
			dv = DW'(len_s[j-1]) << K;
			for (int i = 0; i < 3; i++) begin
				ge[i] = rem_s[j-1][i] >= dv;
				nrem[i] = ge[i] ? rem_s[j-1][i] - dv : rem_s[j-1][i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en) begin
				v_s[j] <= v_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					rem_s[j][i] <= nrem[i];
					q_s[j][i] <= {q_s[j-1][i][QW-2:0], ge[i]};
				end
				len_s[j] <= len_s[j-1];
				cr_s[j] <= cr_s[j-1];
			end
		end
	end

	assign valid_out = v_s[NS-1];
	assign quot = q_s[NS-1];
	assign carry_out = cr_s[NS-1];

endmodule
